### sv/b64sc_pkg.sv
package b64sc_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CHAR   = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        JOB_ENC = 4'b0001,
        JOB_DEC = 4'b0010,
        JOB_ERR = 4'b0100,
        JOB_INC = 4'b1000
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] word;
    } job_t;

    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'(8'd65 + {2'b00, v});
        end else if (v < 6'd52) begin
            r = 8'(8'd71 + {2'b00, v});
        end else if (v < 6'd62) begin
            r = 8'({2'b00, v} - 8'd4);
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    // Bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r = 7'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = 7'(c + 8'd4);
        end else if (c == CHAR_PLUS) begin
            r = 7'd62;
        end else if (c == CHAR_SLASH) begin
            r = 7'd63;
        end else begin
            r = 7'h40;
        end
        return r;
    endfunction

endpackage

### sv/b64sc_front.sv
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       push,
    output job_t       job
);

    logic        dir_reg, dir_next;
    logic [1:0]  count_reg, count_next;
    logic [17:0] held_reg, held_next;
    logic        err_reg, err_next;
    logic [6:0]  sx;
    logic        accept;

    assign accept = in_valid & in_ready;
    assign sx     = char_to_sextet(in_byte);

    always_comb begin
        dir_next   = dir_reg;
        count_next = count_reg;
        held_next  = held_reg;
        err_next   = err_reg;
        push       = 1'b0;
        job.kind   = JOB_INC;
        job.word   = '0;
        if (cfg_we) begin
            dir_next   = cfg_wdata;
            count_next = '0;
            held_next  = '0;
            err_next   = 1'b0;
        end else if (accept) begin
            if (!dir_reg) begin
                if (count_reg < 2'd2) begin
                    held_next  = {held_reg[9:0], in_byte};
                    count_next = 2'(count_reg + 2'd1);
                    if (in_end) begin
                        push       = 1'b1;
                        job.kind   = JOB_INC;
                        count_next = '0;
                        held_next  = '0;
                    end
                end else begin
                    push       = 1'b1;
                    job.kind   = JOB_ENC;
                    job.word   = {held_reg[15:0], in_byte};
                    count_next = '0;
                    held_next  = '0;
                end
            end else if (err_reg) begin
                if (in_end) begin
                    err_next   = 1'b0;
                    count_next = '0;
                    held_next  = '0;
                end
            end else if (sx[6]) begin
                push       = 1'b1;
                job.kind   = JOB_ERR;
                count_next = '0;
                held_next  = '0;
                err_next   = ~in_end;
            end else if (count_reg < 2'd3) begin
                held_next  = {held_reg[11:0], sx[5:0]};
                count_next = 2'(count_reg + 2'd1);
                if (in_end) begin
                    push       = 1'b1;
                    job.kind   = JOB_INC;
                    count_next = '0;
                    held_next  = '0;
                end
            end else begin
                push       = 1'b1;
                job.kind   = JOB_DEC;
                job.word   = {held_reg, sx[5:0]};
                count_next = '0;
                held_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= 1'b0;
            count_reg <= '0;
            held_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            dir_reg   <= dir_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            err_reg   <= err_next;
        end
    end

endmodule

### sv/b64sc_queue.sv
module b64sc_queue
    import b64sc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : PTR_W'(wr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : PTR_W'(rd_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end else if (!do_push && do_pop) begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

### sv/b64sc_back.sv
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output status_t    out_status,
    output logic       out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    status_t    status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;
    logic [5:0] sextet;
    logic [7:0] dec_byte;

    assign load = head_valid & (~valid_reg | out_ready);

    always_comb begin
        case (idx_reg)
            2'd0:    sextet = head_job.word[23:18];
            2'd1:    sextet = head_job.word[17:12];
            2'd2:    sextet = head_job.word[11:6];
            default: sextet = head_job.word[5:0];
        endcase
        case (idx_reg)
            2'd0:    dec_byte = head_job.word[23:16];
            2'd1:    dec_byte = head_job.word[15:8];
            default: dec_byte = head_job.word[7:0];
        endcase
    end

    always_comb begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            unique case (head_job.kind)
                JOB_ENC: begin
                    byte_next   = sextet_to_char(sextet);
                    status_next = ST_OK;
                    last_next   = (idx_reg == 2'd3);
                end
                JOB_DEC: begin
                    byte_next   = dec_byte;
                    status_next = ST_OK;
                    last_next   = (idx_reg == 2'd2);
                end
                JOB_ERR: begin
                    byte_next   = '0;
                    status_next = ST_BAD_CHAR;
                    last_next   = 1'b1;
                end
                default: begin
                    byte_next   = '0;
                    status_next = ST_INCOMPLETE;
                    last_next   = 1'b1;
                end
            endcase
            if (last_next) begin
                pop      = 1'b1;
                idx_next = '0;
            end else begin
                idx_next = 2'(idx_reg + 2'd1);
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

endmodule

### sv/base64_stream_codec.sv
// Base64 stream codec, standard alphabet, no padding.
// Requests enter on the s_ channel: one byte or character in s_tdata, with
// s_tlast marking the final request of a stream. Results leave on the m_
// channel: a character or data byte in m_tdata, a status code in m_tuser and
// m_tlast on the final result caused by one request. cfg_we with cfg_wdata
// selects encoding (0) or decoding (1) and clears the group state; write it
// only while the block is idle.
// An accepted request updates the group state and may become a job for a
// small queue. The output stage expands a job at one result per cycle while
// m_tready is high: four characters per encoded group, three bytes per
// decoded group, one result for an error or an incomplete group. Each job is
// held in the queue and each result in the output register. Throughput is
// bounded by the output stage: three requests per four results when
// encoding, one per cycle when decoding. s_tready falls only when the
// queue is full. Reset clears the direction to encoding, the group state,
// the queue and the output stage. While m_tready is low the output register
// holds its result, the queue fills and s_tready then stalls the sender.
module base64_stream_codec
    import b64sc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // status
    output logic       m_tlast    // out_last
);

    logic    push, pop, q_full, head_valid;
    job_t    push_job, head_job;
    status_t out_status;

    assign s_tready = ~q_full;
    assign m_tuser  = out_status;

    b64sc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .push      (push),
        .job       (push_job)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64sc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status != ST_OK |-> m_tdata == 8'h00)
        else $error("error result carries data");

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status != ST_OK |-> m_tlast)
        else $error("error result not marked last");

    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(head_valid))
        else $error("result produced without a queued job");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into full queue");

endmodule
